FILE: hdl/assert_macros.svh
// assertion macros shared by the steering controller rtl
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds in a cycle -> b holds in the same cycle
`define ASSERT_IMP(lbl, clk_, rst_, a, b, msg) \
  lbl: assert property (@(posedge clk_) disable iff (rst_) (a) |-> (b)) else $error(msg);

// a holds in a cycle -> b holds in the next cycle
`define ASSERT_NXT(lbl, clk_, rst_, a, b, msg) \
  lbl: assert property (@(posedge clk_) disable iff (rst_) (a) |=> (b)) else $error(msg);

`endif

FILE: hdl/ptsc_pkg.sv
// shared types, constants and the arctangent table of the steering controller
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ptsc_pkg;

  // cordic vector width and angle width (Q3.29 radians)
  localparam int XW = 54;
  localparam int ZW = 34;

  localparam logic signed [ZW-1:0] PI29      = 34'sd1686629713;
  localparam logic signed [ZW-1:0] HALF_PI29 = 34'sd843314856;
  localparam logic signed [34:0]   TWO_PI29  = 35'sd3373259426;
  localparam logic signed [XW-1:0] KGAIN28   = 54'sd163008219;
  localparam logic signed [34:0]   STEER_LIM = 35'sd14298;

  typedef enum logic [1:0] {
    REQ_ODOM  = 2'd0,
    REQ_WAYPT = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_RSVD  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    REG_CTE_GAIN  = 2'd0,
    REG_SOFTENING = 2'd1,
    REG_AXLE      = 2'd2,
    REG_CRUISE    = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    MUL_QWZ, MUL_QXY, MUL_QYY, MUL_QZZ, MUL_CY_AX, MUL_SY_AX,
    MUL_CP_DY, MUL_SP_DX, MUL_CTE_G
  } mul_sel_t;

  typedef enum logic [1:0] {MAC_HOLD, MAC_LOAD, MAC_ADD, MAC_SUB} mac_op_t;

  typedef enum logic [3:0] {
    CAP_NONE, CAP_NUM2, CAP_NUM1, CAP_DEN, CAP_YAW, CAP_CYS, CAP_VX, CAP_VY,
    CAP_PYAW_CORD, CAP_PYAW_YAW, CAP_CPS, CAP_CTE, CAP_ST, CAP_WRAP, CAP_OUT, CAP_ZERO
  } cap_t;

  typedef enum logic [2:0] {SRC_QUAT, SRC_PATH, SRC_STEER, SRC_YAW, SRC_PYAW} cord_src_t;

  typedef struct packed {
    logic      in_load;
    logic      wp_write;
    logic      path_clear;
    mul_sel_t  mul_sel;
    mac_op_t   mac_op;
    cap_t      cap;
    logic      cord_start;
    cord_src_t cord_src;
  } dp_cmd_t;

  typedef struct packed {
    req_t       req;
    logic [1:0] path_cnt;
    logic       cord_done;
  } dp_stat_t;

  // atan(2^-i) in Q3.29
  function automatic logic [29:0] atan_entry(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'd421657428;
      5'd1:  v = 30'd248918915;
      5'd2:  v = 30'd131521918;
      5'd3:  v = 30'd66762579;
      5'd4:  v = 30'd33510843;
      5'd5:  v = 30'd16771758;
      5'd6:  v = 30'd8387925;
      5'd7:  v = 30'd4194219;
      5'd8:  v = 30'd2097141;
      5'd9:  v = 30'd1048575;
      5'd10: v = 30'd524288;
      5'd11: v = 30'd262144;
      5'd12: v = 30'd131072;
      5'd13: v = 30'd65536;
      5'd14: v = 30'd32768;
      5'd15: v = 30'd16384;
      5'd16: v = 30'd8192;
      5'd17: v = 30'd4096;
      5'd18: v = 30'd2048;
      5'd19: v = 30'd1024;
      5'd20: v = 30'd512;
      5'd21: v = 30'd256;
      5'd22: v = 30'd128;
      5'd23: v = 30'd64;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/path_tracking_steering_controller.sv
// an odometry item is sequenced through the shared multiplier, accumulator and cordic unit:
// two sin/cos passes, two or three atan2 passes (vehicle yaw, path yaw of a two-point path,
// steering), each with normalization shifts; an all-zero atan2 pair skips its iterations
// empty path: zero result via S_ZERO; waypoint, clear and unused items go back to idle
// one item at a time through the shared cordic unit; the next is accepted once the
// result is posted; reset (sync, rst high): path empty, gain 1.0, softening 1.0, rest zero
`timescale 1ns / 1ps
`default_nettype none

module path_tracking_steering_controller import ptsc_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [30:0]  cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [127:0] s_tdata,  // pos_x, pos_y, quat_x, quat_y, quat_z, quat_w
  input  wire logic [2:0]   s_tuser,  // req_type, path_start
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [47:0]       m_tdata   // speed_cmd, steer_angle, zero pad
);

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [30:0]        speed_cmd;
  logic signed [14:0] steer_angle;

  ptsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ptsc_datapath #(.STEPS(CORDIC_STEPS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_type    (s_tuser[1:0]),
    .pos_x       (s_tdata[31:0]),
    .pos_y       (s_tdata[63:32]),
    .quat_x      (s_tdata[79:64]),
    .quat_y      (s_tdata[95:80]),
    .quat_z      (s_tdata[111:96]),
    .quat_w      (s_tdata[127:112]),
    .path_start  (s_tuser[2]),
    .cmd         (cmd),
    .stat        (stat),
    .speed_cmd   (speed_cmd),
    .steer_angle (steer_angle)
  );

  assign m_tdata = {2'b00, steer_angle, speed_cmd};

endmodule

`default_nettype wire

FILE: hdl/ptsc_cordic.sv
// iterative cordic unit: vectoring (atan2 with normalization) and rotation (cos/sin)
// depends on ptsc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ptsc_cordic import ptsc_pkg::*; #(
  parameter int STEPS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic                 rot_mode,
  input  wire logic signed [XW-1:0] in_x,
  input  wire logic signed [XW-1:0] in_y,
  input  wire logic signed [ZW-1:0] in_a,
  output logic                      done,
  output logic signed [31:0]        res_x,
  output logic signed [31:0]        res_y,
  output logic signed [ZW-1:0]      res_z
);

  localparam int IW = $clog2(STEPS);
  localparam logic [XW-1:0] M_HI = XW'(64'h80_0000_0000);
  localparam logic [XW-1:0] M_LO = XW'(64'h40_0000_0000);

  typedef enum logic [2:0] {C_IDLE, C_MAG, C_NORM, C_ITER, C_FIN} cstate_t;

  cstate_t               cst;
  logic signed [XW-1:0]  x, y;
  logic signed [ZW-1:0]  z, base;
  logic [XW-1:0]         m;
  logic [IW-1:0]         i;
  logic                  neg, rot;

  logic [XW-1:0]         ax, ay;
  logic signed [XW-1:0]  xs, ys;
  logic signed [ZW-1:0]  at;
  logic                  up;

  always_comb begin
    ax = x[XW-1] ? -x : x;
    ay = y[XW-1] ? -y : y;
    xs = x >>> i;
    ys = y >>> i;
    at = ZW'(signed'({1'b0, atan_entry(5'(i))}));
    up = rot ? (z >= 0) : (y <= 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cst  <= C_IDLE;
      done <= 1'b0;
    end else begin
      done <= (cst == C_FIN);
      unique case (cst)
        C_IDLE: begin
          if (start) begin
            i   <= '0;
            rot <= rot_mode;
            if (rot_mode) begin
              x    <= KGAIN28;
              y    <= '0;
              base <= '0;
              cst  <= C_ITER;
              // fold the angle into the convergence range
              if (in_a > HALF_PI29) begin
                z   <= in_a - PI29;
                neg <= 1'b1;
              end else if (in_a < -HALF_PI29) begin
                z   <= in_a + PI29;
                neg <= 1'b1;
              end else begin
                z   <= in_a;
                neg <= 1'b0;
              end
            end else begin
              z   <= '0;
              neg <= 1'b0;
              if (in_x == 0 && in_y == 0) begin
                base <= '0;
                cst  <= C_FIN;
              end else begin
                cst <= C_MAG;
                if (in_x < 0) begin
                  x    <= -in_x;
                  y    <= -in_y;
                  base <= (in_y >= 0) ? PI29 : -PI29;
                end else begin
                  x    <= in_x;
                  y    <= in_y;
                  base <= '0;
                end
              end
            end
          end
        end
        C_MAG: begin
          m   <= (ax > ay) ? ax : ay;
          cst <= C_NORM;
        end
        C_NORM: begin
          // one bit a cycle until the larger magnitude sits in [2^38, 2^39)
          if (m >= M_HI) begin
            x <= x >>> 1;
            y <= y >>> 1;
            m <= m >> 1;
          end else if (m < M_LO) begin
            x <= x <<< 1;
            y <= y <<< 1;
            m <= m << 1;
          end else begin
            cst <= C_ITER;
          end
        end
        C_ITER: begin
          if (up) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - at;
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + at;
          end
          i <= i + 1'b1;
          if (i == IW'(STEPS - 1)) cst <= C_FIN;
        end
        C_FIN: begin
          res_x <= neg ? 32'(-x) : 32'(x);
          res_y <= neg ? 32'(-y) : 32'(y);
          res_z <= base + z;
          cst   <= C_IDLE;
        end
        default: cst <= C_IDLE;
      endcase
    end
  end

  `ASSERT_IMP(a_start_idle, clk, rst, start, cst == C_IDLE, "cordic started while busy")
  `ASSERT_NXT(a_done_pulse, clk, rst, done, !done, "cordic done longer than one cycle")

endmodule

`default_nettype wire

FILE: hdl/ptsc_datapath.sv
// datapath: config registers, path store, shared multiplier and accumulator,
// cordic unit and result registers; depends on ptsc_pkg and ptsc_cordic
`timescale 1ns / 1ps
`default_nettype none

module ptsc_datapath import ptsc_pkg::*; #(
  parameter int STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [30:0]        cfg_data,
  input  wire logic [1:0]         req_type,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [15:0] quat_x,
  input  wire logic signed [15:0] quat_y,
  input  wire logic signed [15:0] quat_z,
  input  wire logic signed [15:0] quat_w,
  input  wire logic               path_start,
  input  wire dp_cmd_t            cmd,
  output dp_stat_t                stat,
  output logic [30:0]             speed_cmd,
  output logic signed [14:0]      steer_angle
);

  localparam logic signed [63:0] HALF28 = 64'sd134217728;
  localparam logic signed [63:0] ONE28  = 64'sd268435456;

  logic [15:0] cte_gain;
  logic [30:0] speed_softening, axle_offset, cruise_speed;

  req_t               req_r;
  logic signed [31:0] px, py, w1x, w1y, w2x, w2y;
  logic signed [15:0] qx, qy, qz, qw;
  logic               pstart;
  logic [1:0]         cnt, eff_cnt;

  logic signed [35:0] ma, cte;
  logic signed [34:0] mb, dx, dy, st, st_rnd;
  logic signed [70:0] prod;
  logic signed [63:0] p, acc, rnd28;
  logic signed [XW-1:0] num, den, c_in_x, c_in_y;
  logic signed [ZW-1:0] yaw, pyaw, c_in_a, c_z;
  logic signed [31:0] cy, sy, cp, sp, c_x, c_y;
  logic signed [33:0] vx, vy;
  logic [31:0]        den_sum;
  logic               c_rot, c_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cte_gain        <= 16'd256;
      speed_softening <= 31'd65536;
      axle_offset     <= '0;
      cruise_speed    <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CTE_GAIN:  cte_gain        <= cfg_data[15:0];
        REG_SOFTENING: speed_softening <= cfg_data;
        REG_AXLE:      axle_offset     <= cfg_data;
        REG_CRUISE:    cruise_speed    <= cfg_data;
      endcase
    end
  end

  // path store: a start flag empties it first, duplicates of point 0 are dropped
  assign eff_cnt = pstart ? 2'd0 : cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.path_clear) begin
      cnt <= '0;
    end else if (cmd.wp_write) begin
      if (eff_cnt == 2'd0) begin
        w1x <= px;
        w1y <= py;
        cnt <= 2'd1;
      end else if (eff_cnt == 2'd1 && (px != w1x || py != w1y)) begin
        w2x <= px;
        w2y <= py;
        cnt <= 2'd2;
      end else begin
        cnt <= eff_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      req_r  <= req_t'(req_type);
      px     <= pos_x;
      py     <= pos_y;
      qx     <= quat_x;
      qy     <= quat_y;
      qz     <= quat_z;
      qw     <= quat_w;
      pstart <= path_start;
    end
  end

  assign dy = 35'(w1y) - 35'(vy);
  assign dx = 35'(w1x) - 35'(vx);

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_QWZ:   begin ma = 36'(qw);  mb = 35'(qz); end
      MUL_QXY:   begin ma = 36'(qx);  mb = 35'(qy); end
      MUL_QYY:   begin ma = 36'(qy);  mb = 35'(qy); end
      MUL_QZZ:   begin ma = 36'(qz);  mb = 35'(qz); end
      MUL_CY_AX: begin ma = 36'(cy);  mb = 35'(signed'({1'b0, axle_offset})); end
      MUL_SY_AX: begin ma = 36'(sy);  mb = 35'(signed'({1'b0, axle_offset})); end
      MUL_CP_DY: begin ma = 36'(cp);  mb = dy; end
      MUL_SP_DX: begin ma = 36'(sp);  mb = dx; end
      MUL_CTE_G: begin ma = cte;      mb = 35'(signed'({1'b0, cte_gain})); end
      default:   begin ma = '0;       mb = '0; end
    endcase
  end

  assign prod  = ma * mb;
  assign rnd28 = (acc + HALF28) >>> 28;

  always_ff @(posedge clk) begin
    p <= 64'(prod);
    unique case (cmd.mac_op)
      MAC_HOLD: acc <= acc;
      MAC_LOAD: acc <= p;
      MAC_ADD:  acc <= acc + p;
      MAC_SUB:  acc <= acc - p;
    endcase
  end

  // cordic operand selection
  assign den_sum = 32'(speed_softening) + 32'(cruise_speed);

  always_comb begin
    c_in_x = den;
    c_in_y = num;
    c_in_a = yaw;
    c_rot  = 1'b0;
    unique case (cmd.cord_src)
      SRC_QUAT: ;
      SRC_PATH: begin
        c_in_x = XW'(33'(w2x) - 33'(w1x));
        c_in_y = XW'(33'(w2y) - 33'(w1y));
      end
      SRC_STEER: begin
        c_in_x = XW'(signed'({1'b0, den_sum, 8'd0}));
        c_in_y = signed'(acc[XW-1:0]);
      end
      SRC_YAW:  c_rot = 1'b1;
      SRC_PYAW: begin
        c_rot  = 1'b1;
        c_in_a = pyaw;
      end
      default: ;
    endcase
  end

  ptsc_cordic #(.STEPS(STEPS)) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.cord_start),
    .rot_mode (c_rot),
    .in_x     (c_in_x),
    .in_y     (c_in_y),
    .in_a     (c_in_a),
    .done     (c_done),
    .res_x    (c_x),
    .res_y    (c_y),
    .res_z    (c_z)
  );

  assign st_rnd = (st + 35'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    unique case (cmd.cap)
      CAP_NONE:      ;
      CAP_NUM2:      num  <= signed'({acc[XW-2:0], 1'b0});
      CAP_NUM1:      num  <= signed'(acc[XW-1:0]);
      CAP_DEN:       den  <= XW'(ONE28 - (acc <<< 1));
      CAP_YAW:       yaw  <= c_z;
      CAP_CYS: begin
        cy <= c_x;
        sy <= c_y;
      end
      CAP_VX:        vx   <= 34'(px) + 34'(rnd28);
      CAP_VY:        vy   <= 34'(py) + 34'(rnd28);
      CAP_PYAW_CORD: pyaw <= c_z;
      CAP_PYAW_YAW:  pyaw <= yaw;
      CAP_CPS: begin
        cp <= c_x;
        sp <= c_y;
      end
      CAP_CTE:       cte  <= 36'(rnd28);
      CAP_ST:        st   <= 35'(pyaw) - 35'(yaw) + 35'(c_z);
      CAP_WRAP: begin
        if (st > 35'(PI29))       st <= st - TWO_PI29;
        else if (st < -35'(PI29)) st <= st + TWO_PI29;
      end
      CAP_OUT: begin
        speed_cmd <= cruise_speed;
        if (st_rnd > STEER_LIM)       steer_angle <= 15'(STEER_LIM);
        else if (st_rnd < -STEER_LIM) steer_angle <= 15'(-STEER_LIM);
        else                          steer_angle <= 15'(st_rnd);
      end
      CAP_ZERO: begin
        speed_cmd   <= '0;
        steer_angle <= '0;
      end
      default: ;
    endcase
  end

  assign stat.req       = req_r;
  assign stat.path_cnt  = cnt;
  assign stat.cord_done = c_done;

endmodule

`default_nettype wire

FILE: hdl/ptsc_ctrl.sv
// controller state machine: sequences multiplies, captures and cordic passes
// depends on ptsc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ptsc_ctrl import ptsc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  wire logic     m_tready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [5:0] {
    S_IDLE, S_DISP, S_ZERO,
    S_Q1, S_Q2, S_Q3, S_Q4, S_Q5, S_Q6, S_Q7, S_WYAW,
    S_R1, S_WCYS, S_V1, S_V2, S_V3, S_V4,
    S_P1, S_WPY, S_R2, S_WCPS,
    S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_C7, S_WST,
    S_WRAP, S_OUT
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign s_tready  = (state == S_IDLE);
  assign slot_free = !m_tvalid || m_tready;

  always_comb begin
    state_next     = state;
    cmd.in_load    = 1'b0;
    cmd.wp_write   = 1'b0;
    cmd.path_clear = 1'b0;
    cmd.mul_sel    = MUL_QWZ;
    cmd.mac_op     = MAC_HOLD;
    cmd.cap        = CAP_NONE;
    cmd.cord_start = 1'b0;
    cmd.cord_src   = SRC_QUAT;
    unique case (state)
      S_IDLE: if (s_tvalid) begin
        cmd.in_load = 1'b1;
        state_next  = S_DISP;
      end
      S_DISP: begin
        unique case (stat.req)
          REQ_WAYPT: begin cmd.wp_write = 1'b1;   state_next = S_IDLE; end
          REQ_CLEAR: begin cmd.path_clear = 1'b1; state_next = S_IDLE; end
          REQ_ODOM:  state_next = (stat.path_cnt == 2'd0) ? S_ZERO : S_Q1;
          REQ_RSVD:  state_next = S_IDLE;
        endcase
      end
      S_ZERO: if (slot_free) begin
        cmd.cap    = CAP_ZERO;
        state_next = S_IDLE;
      end
      // yaw numerator 2(wz+xy), denominator 1-2(yy+zz)
      S_Q1: begin cmd.mul_sel = MUL_QWZ; state_next = S_Q2; end
      S_Q2: begin cmd.mac_op = MAC_LOAD; cmd.mul_sel = MUL_QXY; state_next = S_Q3; end
      S_Q3: begin cmd.mac_op = MAC_ADD;  cmd.mul_sel = MUL_QYY; state_next = S_Q4; end
      S_Q4: begin
        cmd.cap     = CAP_NUM2;
        cmd.mac_op  = MAC_LOAD;
        cmd.mul_sel = MUL_QZZ;
        state_next  = S_Q5;
      end
      S_Q5: begin cmd.mac_op = MAC_ADD; state_next = S_Q6; end
      S_Q6: begin cmd.cap = CAP_DEN; state_next = S_Q7; end
      S_Q7: begin
        cmd.cord_start = 1'b1;
        cmd.cord_src   = SRC_QUAT;
        state_next     = S_WYAW;
      end
      S_WYAW: if (stat.cord_done) begin cmd.cap = CAP_YAW; state_next = S_R1; end
      S_R1: begin
        cmd.cord_start = 1'b1;
        cmd.cord_src   = SRC_YAW;
        state_next     = S_WCYS;
      end
      S_WCYS: if (stat.cord_done) begin cmd.cap = CAP_CYS; state_next = S_V1; end
      // reference point moved forward along the vehicle heading
      S_V1: begin cmd.mul_sel = MUL_CY_AX; state_next = S_V2; end
      S_V2: begin cmd.mac_op = MAC_LOAD; cmd.mul_sel = MUL_SY_AX; state_next = S_V3; end
      S_V3: begin cmd.cap = CAP_VX; cmd.mac_op = MAC_LOAD; state_next = S_V4; end
      S_V4: begin cmd.cap = CAP_VY; state_next = S_P1; end
      S_P1: begin
        if (stat.path_cnt == 2'd2) begin
          cmd.cord_start = 1'b1;
          cmd.cord_src   = SRC_PATH;
          state_next     = S_WPY;
        end else begin
          // single point: path yaw follows the vehicle yaw
          cmd.cap    = CAP_PYAW_YAW;
          state_next = S_R2;
        end
      end
      S_WPY: if (stat.cord_done) begin cmd.cap = CAP_PYAW_CORD; state_next = S_R2; end
      S_R2: begin
        cmd.cord_start = 1'b1;
        cmd.cord_src   = SRC_PYAW;
        state_next     = S_WCPS;
      end
      S_WCPS: if (stat.cord_done) begin cmd.cap = CAP_CPS; state_next = S_C1; end
      // cross-track error cos*dy - sin*dx, then times gain
      S_C1: begin cmd.mul_sel = MUL_CP_DY; state_next = S_C2; end
      S_C2: begin cmd.mac_op = MAC_LOAD; cmd.mul_sel = MUL_SP_DX; state_next = S_C3; end
      S_C3: begin cmd.mac_op = MAC_SUB; state_next = S_C4; end
      S_C4: begin cmd.cap = CAP_CTE; state_next = S_C5; end
      S_C5: begin cmd.mul_sel = MUL_CTE_G; state_next = S_C6; end
      S_C6: begin cmd.mac_op = MAC_LOAD; state_next = S_C7; end
      S_C7: begin
        cmd.cord_start = 1'b1;
        cmd.cord_src   = SRC_STEER;
        state_next     = S_WST;
      end
      S_WST: if (stat.cord_done) begin cmd.cap = CAP_ST; state_next = S_WRAP; end
      S_WRAP: begin cmd.cap = CAP_WRAP; state_next = S_OUT; end
      S_OUT: if (slot_free) begin
        cmd.cap    = CAP_OUT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_OUT || state == S_ZERO) && slot_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  `ASSERT_NXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready, "accepted while busy")
  `ASSERT_IMP(a_done_in_wait, clk, rst, stat.cord_done, state == S_WYAW || state == S_WCYS || state == S_WPY || state == S_WCPS || state == S_WST, "cordic result not awaited")
  `ASSERT_NXT(a_result_posted, clk, rst, state == S_OUT && !m_tvalid, m_tvalid, "result not posted")

endmodule

`default_nettype wire

FILE: tb/tb_path_tracking_steering_controller.sv
// self-checking testbench of path_tracking_steering_controller: directed and random stream
// traffic, stalls on both sides, checked against a cycle-free predictor; needs ptsc_pkg, rtl
`timescale 1ns / 1ps

module tb_path_tracking_steering_controller;
  import ptsc_pkg::*;

  localparam longint PI_Q29    = 64'sd1686629713;
  localparam longint HPI_Q29   = 64'sd843314856;
  localparam longint TWOPI_Q29 = 64'sd3373259426;
  localparam longint GAIN_Q28  = 64'sd163008219;
  localparam longint STEER_MAX = 64'sd14298;
  localparam int     STEPS     = 16;
  localparam int     LIMIT     = 1500000;
  localparam int     SETTLE    = 400;

  localparam longint ATAN_Q29 [16] = '{
    421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
    8387925, 4194219, 2097141, 1048575, 524288, 262144,
    131072, 65536, 32768, 16384};

  typedef struct {
    req_t               req;
    logic signed [31:0] px, py;
    logic signed [15:0] qx, qy, qz, qw;
    logic               start;
  } req_item_t;

  typedef struct {
    logic [30:0] speed;
    logic [14:0] steer;
  } steer_cmd_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [30:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [47:0]  m_tdata;

  path_tracking_steering_controller u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // predictor state and register copies
  longint unsigned gain_r, soft_r, axle_r, cruise_r;
  longint          wp0_x, wp0_y, wp1_x, wp1_y;
  int              wp_count;

  req_item_t  pending_items[$];
  steer_cmd_t expected_cmds[$];
  req_item_t  cur;
  int         errors = 0;
  int         cycles = 0;
  int         items_sent = 0;
  int         cmds_checked = 0;

  task automatic queue_item(input req_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint labs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint vec_angle(longint y, longint x);
    longint base, z, m, xo;
    base = 0;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      base = (y <= 0) ? PI_Q29 : -PI_Q29;
    end
    m = labs(x) > labs(y) ? labs(x) : labs(y);
    while (m >= (64'sd1 <<< 39)) begin
      x = x >>> 1;
      y = y >>> 1;
      m = m >>> 1;
    end
    while (m < (64'sd1 <<< 38)) begin
      x = x * 2;
      y = y * 2;
      m = m * 2;
    end
    for (int i = 0; i < STEPS; i++) begin
      xo = x;
      if (y > 0) begin
        x = x + (y >>> i);
        y = y - (xo >>> i);
        z = z + ATAN_Q29[i];
      end else begin
        x = x - (y >>> i);
        y = y + (xo >>> i);
        z = z - ATAN_Q29[i];
      end
    end
    return base + z;
  endfunction

  task automatic rotate_unit(input longint a, output longint c, output longint s);
    bit     flip;
    longint x, y, xo;
    flip = 0;
    x = GAIN_Q28;
    y = 0;
    if (a > HPI_Q29) begin
      a = a - PI_Q29;
      flip = 1;
    end else if (a < -HPI_Q29) begin
      a = a + PI_Q29;
      flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      xo = x;
      if (a >= 0) begin
        x = x - (y >>> i);
        y = y + (xo >>> i);
        a = a - ATAN_Q29[i];
      end else begin
        x = x + (y >>> i);
        y = y - (xo >>> i);
        a = a + ATAN_Q29[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  // updates the path and queues the steering command an item causes
  task automatic steer_predict(input req_item_t it);
    longint     px, py, qx, qy, qz, qw, num, den, yaw, cy, sy, vx, vy;
    longint     pyaw, cp, sp, cte, st, st13;
    steer_cmd_t cmd;
    px = it.px;
    py = it.py;
    case (it.req)
      REQ_WAYPT: begin
        if (it.start) wp_count = 0;
        if (wp_count == 0) begin
          wp0_x = px;
          wp0_y = py;
          wp_count = 1;
        end else if (wp_count == 1 && (px != wp0_x || py != wp0_y)) begin
          wp1_x = px;
          wp1_y = py;
          wp_count = 2;
        end
      end
      REQ_CLEAR: wp_count = 0;
      REQ_ODOM: begin
        if (wp_count == 0) begin
          cmd.speed = '0;
          cmd.steer = '0;
        end else begin
          qx = it.qx;
          qy = it.qy;
          qz = it.qz;
          qw = it.qw;
          num = 2 * (qw * qz + qx * qy);
          den = (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz);
          yaw = vec_angle(num, den);
          rotate_unit(yaw, cy, sy);
          vx = px + rnd_shift(cy * longint'(axle_r), 28);
          vy = py + rnd_shift(sy * longint'(axle_r), 28);
          pyaw = (wp_count >= 2) ? vec_angle(wp1_y - wp0_y, wp1_x - wp0_x) : yaw;
          rotate_unit(pyaw, cp, sp);
          cte = rnd_shift(cp * (wp0_y - vy) - sp * (wp0_x - vx), 28);
          num = cte * longint'(gain_r);
          den = longint'(soft_r + cruise_r) * 256;
          st = (pyaw - yaw) + vec_angle(num, den);
          while (st > PI_Q29) st = st - TWOPI_Q29;
          while (st < -PI_Q29) st = st + TWOPI_Q29;
          st13 = rnd_shift(st, 16);
          if (st13 > STEER_MAX) st13 = STEER_MAX;
          else if (st13 < -STEER_MAX) st13 = -STEER_MAX;
          cmd.speed = cruise_r[30:0];
          cmd.steer = st13[14:0];
        end
        expected_cmds.insert(expected_cmds.size(), cmd);
      end
      default: ;
    endcase
  endtask

  // random stall, off during a quiet window
  function automatic bit stall_now();
    if (cycles > 30000 && cycles < 60000) return 0;
    return $urandom_range(0, 99) < 25;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        steer_predict(cur);
        items_sent++;
      end
      if (pending_items.size() > 0 && !stall_now()) begin
        cur = pending_items.pop_front();
        s_tdata <= {cur.qw, cur.qz, cur.qy, cur.qx, cur.py, cur.px};
        s_tuser <= {cur.start, cur.req};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    steer_cmd_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_cmds.size() == 0) begin
          $error("unexpected item: speed_cmd %0d steer_angle %0d",
                 m_tdata[30:0], $signed(m_tdata[45:31]));
          errors++;
        end else begin
          want = expected_cmds.pop_front();
          cmds_checked++;
          if (m_tdata[30:0] !== want.speed) begin
            $error("speed_cmd: expected %0d, got %0d", want.speed, m_tdata[30:0]);
            errors++;
          end
          if (m_tdata[45:31] !== want.steer) begin
            $error("steer_angle: expected %0d, got %0d",
                   $signed(want.steer), $signed(m_tdata[45:31]));
            errors++;
          end
        end
      end
      m_tready <= !stall_now();
    end
  end

  function automatic req_item_t mk(req_t r, logic [31:0] x, logic [31:0] y, int st = 0,
                                   int a = 0, int b = 0, int c = 0, int d = 16384);
    req_item_t it;
    it.req = r;
    it.px = x;
    it.py = y;
    it.start = st[0];
    it.qx = 16'(a);
    it.qy = 16'(b);
    it.qz = 16'(c);
    it.qw = 16'(d);
    return it;
  endfunction

  function automatic int rnd_quat();
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  function automatic logic [31:0] rnd_pos(logic [31:0] near);
    case ($urandom_range(0, 3))
      0: return $urandom;
      default: return near + 32'($signed($urandom_range(0, 32'h3FFFFF)) - 32'sh200000);
    endcase
  endfunction

  function automatic req_item_t rnd_odom(logic [31:0] x, logic [31:0] y);
    return mk(REQ_ODOM, rnd_pos(x), rnd_pos(y), int'($urandom_range(0, 1)),
              rnd_quat(), rnd_quat(), rnd_quat(), rnd_quat());
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [30:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_CTE_GAIN:  gain_r = val[15:0];
      REG_SOFTENING: soft_r = val;
      REG_AXLE:      axle_r = val;
      REG_CRUISE:    cruise_r = val;
    endcase
  endtask

  task automatic set_regs(logic [15:0] g, logic [30:0] s, logic [30:0] a, logic [30:0] c);
    write_reg(REG_CTE_GAIN, 31'(g));
    write_reg(REG_SOFTENING, s);
    write_reg(REG_AXLE, a);
    write_reg(REG_CRUISE, c);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || s_tvalid || expected_cmds.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // well-formed path runs with random content, plus some noise
  task automatic random_items(int n);
    logic [31:0] bx, by;
    int          made;
    made = 0;
    while (made < n) begin
      bx = $urandom;
      by = $urandom;
      case ($urandom_range(0, 9))
        0: begin
          queue_item(mk(REQ_CLEAR, $urandom, $urandom, int'($urandom_range(0, 1))));
          made++;
        end
        1: queue_item(mk(REQ_RSVD, $urandom, $urandom, int'($urandom_range(0, 1))));
        default: begin
          queue_item(mk(REQ_WAYPT, bx, by, 1));
          if ($urandom_range(0, 3) == 0) begin
            queue_item(mk(REQ_WAYPT, bx, by, 0));
            made++;
          end
          if ($urandom_range(0, 4) != 0) begin
            queue_item(mk(REQ_WAYPT, rnd_pos(bx), rnd_pos(by), 0));
            made++;
          end
          if ($urandom_range(0, 3) == 0) begin
            queue_item(mk(REQ_WAYPT, $urandom, $urandom, 0));
            made++;
          end
          made++;
          repeat ($urandom_range(1, 5)) begin
            queue_item(rnd_odom(bx, by));
            made++;
          end
        end
      endcase
    end
  endtask

  initial begin
    gain_r = 256;
    soft_r = 65536;
    axle_r = 0;
    cruise_r = 0;
    wp_count = 0;
    wp0_x = 0;
    wp0_y = 0;
    wp1_x = 0;
    wp1_y = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty path, duplicates, single point, extremes, clear, unused request
    queue_item(mk(REQ_ODOM, 32'h7FFFFFFF, 32'h80000000));
    queue_item(mk(REQ_WAYPT, 32'h00010000, 32'h00020000, 1));
    queue_item(mk(REQ_ODOM, 0, 0, 0, 0, 0, 0, 0));
    queue_item(mk(REQ_WAYPT, 32'h00010000, 32'h00020000, 0));
    queue_item(mk(REQ_ODOM, 32'h00008000, 32'hFFFF0000, 0, 0, 0, 16384, 0));
    queue_item(mk(REQ_WAYPT, 32'h00050000, 32'h00020000, 0));
    queue_item(mk(REQ_WAYPT, 32'h7FFFFFFF, 32'h7FFFFFFF, 0));
    queue_item(mk(REQ_ODOM, 32'h00030000, 32'h00040000, 0, 0, 0, -16384, 0));
    queue_item(mk(REQ_ODOM, 32'h80000000, 32'h7FFFFFFF, 1,
                  16384, -16384, 16384, -16384));
    queue_item(mk(REQ_ODOM, 32'h7FFFFFFF, 32'h80000000, 0,
                  -16384, 16384, -16384, 16384));
    queue_item(mk(REQ_RSVD, 32'hFFFFFFFF, 32'hFFFFFFFF, 1));
    queue_item(mk(REQ_ODOM, 0, 0, 0, 0, 11585, 0, 11585));
    queue_item(mk(REQ_CLEAR, 0, 0));
    queue_item(mk(REQ_ODOM, 32'h00010000, 0));
    queue_item(mk(REQ_WAYPT, 32'h80000000, 32'h80000000, 1));
    queue_item(mk(REQ_WAYPT, 32'h7FFFFFFF, 32'h80000000, 1));
    queue_item(mk(REQ_WAYPT, 32'h80000000, 32'h7FFFFFFF, 0));
    queue_item(mk(REQ_ODOM, 0, 0, 0, 0, 0, 11585, 11585));
    queue_item(mk(REQ_ODOM, 32'h80000000, 32'h80000000, 0, 0, 0, 0, -16384));
    random_items(120);
    drain();

    set_regs(16'hFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
    queue_item(mk(REQ_WAYPT, 32'h80000000, 32'h7FFFFFFF, 1));
    queue_item(mk(REQ_ODOM, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 16384, 0));
    random_items(120);
    drain();

    set_regs('0, '0, '0, '0);
    random_items(120);
    drain();

    set_regs(16'hFFFF, '0, 31'h00080000, '0);
    random_items(100);
    drain();

    set_regs(16'($urandom), 31'($urandom_range(0, 32'h000FFFFF)),
             31'($urandom_range(0, 32'h0007FFFF)), 31'($urandom_range(0, 32'h000FFFFF)));
    random_items(120);
    drain();

    $display("sent %0d items over 5 register settings, checked %0d steering commands",
             items_sent, cmds_checked);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/ptsc_pkg.sv
hdl/ptsc_cordic.sv
hdl/ptsc_datapath.sv
hdl/ptsc_ctrl.sv
hdl/path_tracking_steering_controller.sv
tb/tb_path_tracking_steering_controller.sv
